// File: hw/rtl/alep_pkg.sv
// ----------------------------------------------------------------------------
// alep_pkg
// Shared types, event codes and match strings for the link event parser.
// ----------------------------------------------------------------------------
package alep_pkg;

  localparam int LEN_WIDTH_DEF = 16;

  // Result event codes
  localparam logic [2:0] EV_CONNECTED = 3'd0;
  localparam logic [2:0] EV_CLOSED    = 3'd1;
  localparam logic [2:0] EV_PKT_START = 3'd2;
  localparam logic [2:0] EV_PAYLOAD   = 3'd3;
  localparam logic [2:0] EV_TAKEOVER  = 3'd4;

  // Match string lengths
  localparam logic [3:0] CLOSED_LEN  = 4'd5;
  localparam logic [3:0] CONNECT_LEN = 4'd6;
  localparam logic [3:0] IPD_LEN     = 4'd4;
  localparam logic [3:0] START_LEN   = 4'd10;

  // Links at or above this number are never named for closing
  localparam logic [3:0] CLOSE_LIMIT = 4'd5;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  link;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic        was_active;
    logic        close_old;
    logic [3:0]  old_link;
  } out_item_t;

  // "OSED\r" (tail after "n,CL")
  function automatic logic [7:0] closed_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h4F;
      4'd1:    c = 8'h53;
      4'd2:    c = 8'h45;
      4'd3:    c = 8'h44;
      4'd4:    c = CH_CR;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "NNECT\r" (tail after "n,CO")
  function automatic logic [7:0] connect_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h4E;
      4'd1:    c = 8'h4E;
      4'd2:    c = 8'h45;
      4'd3:    c = 8'h43;
      4'd4:    c = 8'h54;
      4'd5:    c = CH_CR;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "IPD," (tail after '+')
  function automatic logic [7:0] ipd_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h49;
      4'd1:    c = 8'h50;
      4'd2:    c = 8'h44;
      4'd3:    c = CH_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Start-request token carried in a foreign link's payload
  function automatic logic [7:0] start_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h59;
      4'd1:    c = 8'h4F;
      4'd2:    c = 8'h4C;
      4'd3:    c = 8'h4B;
      4'd4:    c = 8'h41;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h42;
      4'd7:    c = 8'h4C;
      4'd8:    c = 8'h53;
      4'd9:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/alep_in_stage.sv
// ----------------------------------------------------------------------------
// alep_in_stage
// Input register: holds one accepted transaction for the parser.
// ----------------------------------------------------------------------------
module alep_in_stage
  import alep_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     adv,
  output logic     s1_valid,
  output in_item_t s1_data
);

  logic     valid_r;
  in_item_t data_r;

  assign in_ready = !valid_r || adv;
  assign s1_valid = valid_r;
  assign s1_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// File: hw/rtl/alep_parser.sv
// ----------------------------------------------------------------------------
// alep_parser
// Line parser state and its next-state / result logic, one byte per cycle while en is high.
// ----------------------------------------------------------------------------
module alep_parser
  import alep_pkg::*;
#(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  in_item_t  item,
  output logic      res_valid,
  output out_item_t res
);

  localparam logic [3:0] PH_LINE      = 4'd0;
  localparam logic [3:0] PH_SKIP_EOL  = 4'd1;
  localparam logic [3:0] PH_SKIP_CRLF = 4'd2;
  localparam logic [3:0] PH_DIG_COMMA = 4'd3;
  localparam logic [3:0] PH_DIG_C     = 4'd4;
  localparam logic [3:0] PH_DIG_LO    = 4'd5;
  localparam logic [3:0] PH_M_CLOSED  = 4'd6;
  localparam logic [3:0] PH_M_CONNECT = 4'd7;
  localparam logic [3:0] PH_M_IPD     = 4'd8;
  localparam logic [3:0] PH_IPD_LINK  = 4'd9;
  localparam logic [3:0] PH_IPD_COMMA = 4'd10;
  localparam logic [3:0] PH_IPD_LEN   = 4'd11;
  localparam logic [3:0] PH_M_START   = 4'd12;
  localparam logic [3:0] PH_PAYLOAD   = 4'd13;

  logic [3:0]           phase_r, phase_nxt;
  logic [3:0]           mpos_r, mpos_nxt;
  logic [3:0]           pend_r, pend_nxt;
  logic [LEN_WIDTH-1:0] acc_r, acc_nxt;
  logic [LEN_WIDTH-1:0] left_r, left_nxt;
  logic                 act_vld_r, act_vld_nxt;   // no active link when clear
  logic [3:0]           act_r, act_nxt;

  logic [7:0]           b;
  logic                 eol, digit;
  logic [3:0]           eff_phase;
  logic                 hold_crlf;
  logic [3:0]           mpos_inc;
  logic                 is_active;
  logic [LEN_WIDTH-1:0] left_dec;
  logic [15:0]          len_out;

  assign b         = item.rx_byte;
  assign eol       = (b == CH_CR) || (b == CH_LF);
  assign digit     = (b >= 8'h30) && (b <= 8'h39);
  assign hold_crlf = (phase_r == PH_SKIP_CRLF) && eol;
  assign eff_phase = (phase_r == PH_SKIP_CRLF) ? PH_LINE : phase_r;
  assign mpos_inc  = mpos_r + 4'd1;
  assign is_active = act_vld_r && (pend_r == act_r);
  assign left_dec  = left_r - LEN_WIDTH'(1);
  assign len_out   = 16'(acc_r);

  always_comb begin
    phase_nxt   = phase_r;
    mpos_nxt    = mpos_r;
    pend_nxt    = pend_r;
    acc_nxt     = acc_r;
    left_nxt    = left_r;
    act_vld_nxt = act_vld_r;
    act_nxt     = act_r;
    res_valid   = 1'b0;
    res         = '0;

    if (item.timed_out) begin
      phase_nxt = PH_LINE;
      mpos_nxt  = 4'd0;
      acc_nxt   = '0;
      left_nxt  = '0;
    end else if (!hold_crlf) begin
      case (eff_phase)
        PH_LINE: begin
          mpos_nxt = 4'd0;
          if (digit) begin
            pend_nxt  = b[3:0];
            phase_nxt = PH_DIG_COMMA;
          end else if (b == CH_PLUS) begin
            phase_nxt = PH_M_IPD;
          end else begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
          end
        end
        PH_SKIP_EOL: begin
          if (eol) phase_nxt = PH_SKIP_CRLF;
        end
        PH_DIG_COMMA: begin
          if (b == CH_COMMA) begin
            phase_nxt = PH_DIG_C;
          end else begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end
        end
        PH_DIG_C: begin
          if (b == CH_C) begin
            phase_nxt = PH_DIG_LO;
          end else begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end
        end
        PH_DIG_LO: begin
          mpos_nxt = 4'd0;
          if (b == CH_L) begin
            phase_nxt = PH_M_CLOSED;
          end else if (b == CH_O) begin
            phase_nxt = PH_M_CONNECT;
          end else begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
          end
        end
        PH_M_CLOSED: begin
          if (mpos_r >= CLOSED_LEN || closed_ch(mpos_r) != b) begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end else if (mpos_inc != CLOSED_LEN) begin
            mpos_nxt = mpos_inc;
          end else begin
            phase_nxt      = PH_SKIP_EOL;
            mpos_nxt       = 4'd0;
            res_valid      = 1'b1;
            res.event_res  = EV_CLOSED;
            res.link       = pend_r;
            res.was_active = is_active;
            if (is_active) act_vld_nxt = 1'b0;
          end
        end
        PH_M_CONNECT: begin
          if (mpos_r >= CONNECT_LEN || connect_ch(mpos_r) != b) begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end else if (mpos_inc != CONNECT_LEN) begin
            mpos_nxt = mpos_inc;
          end else begin
            phase_nxt     = PH_SKIP_EOL;
            mpos_nxt      = 4'd0;
            res_valid     = 1'b1;
            res.event_res = EV_CONNECTED;
            res.link      = pend_r;
          end
        end
        PH_M_IPD: begin
          if (mpos_r >= IPD_LEN || ipd_ch(mpos_r) != b) begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end else if (mpos_inc != IPD_LEN) begin
            mpos_nxt = mpos_inc;
          end else begin
            phase_nxt = PH_IPD_LINK;
            mpos_nxt  = 4'd0;
          end
        end
        PH_IPD_LINK: begin
          if (digit) begin
            pend_nxt  = b[3:0];
            phase_nxt = PH_IPD_COMMA;
          end else begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end
        end
        PH_IPD_COMMA: begin
          if (b == CH_COMMA) begin
            phase_nxt = PH_IPD_LEN;
            acc_nxt   = '0;
          end else begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end
        end
        PH_IPD_LEN: begin
          if (digit) begin
            // acc * 10 + digit, wrapping at the counter width
            acc_nxt = (acc_r << 3) + (acc_r << 1) + LEN_WIDTH'(b[3:0]);
          end else if (acc_r == '0 || b != CH_COLON) begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end else if (is_active) begin
            left_nxt      = acc_r;
            phase_nxt     = PH_PAYLOAD;
            res_valid     = 1'b1;
            res.event_res = EV_PKT_START;
            res.link      = pend_r;
            res.length    = len_out;
          end else begin
            phase_nxt = PH_M_START;
            mpos_nxt  = 4'd0;
          end
        end
        PH_M_START: begin
          if (mpos_r >= START_LEN || start_ch(mpos_r) != b) begin
            phase_nxt = eol ? PH_SKIP_CRLF : PH_SKIP_EOL;
            mpos_nxt  = 4'd0;
          end else if (mpos_inc != START_LEN) begin
            mpos_nxt = mpos_inc;
          end else begin
            phase_nxt     = PH_SKIP_EOL;
            mpos_nxt      = 4'd0;
            act_vld_nxt   = 1'b1;
            act_nxt       = pend_r;
            res_valid     = 1'b1;
            res.event_res = EV_TAKEOVER;
            res.link      = pend_r;
            if (act_vld_r && act_r < CLOSE_LIMIT) begin
              res.close_old = 1'b1;
              res.old_link  = act_r;
            end
          end
        end
        PH_PAYLOAD: begin
          left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_LINE;
          res_valid     = 1'b1;
          res.event_res = EV_PAYLOAD;
          res.link      = act_vld_r ? act_r : 4'hF;
          res.data_byte = b;
        end
        default: begin
          phase_nxt = PH_LINE;
          mpos_nxt  = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LINE;
      mpos_r    <= 4'd0;
      pend_r    <= 4'd0;
      acc_r     <= '0;
      left_r    <= '0;
      act_vld_r <= 1'b0;
      act_r     <= 4'd0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      mpos_r    <= mpos_nxt;
      pend_r    <= pend_nxt;
      acc_r     <= acc_nxt;
      left_r    <= left_nxt;
      act_vld_r <= act_vld_nxt;
      act_r     <= act_nxt;
    end
  end

endmodule

// File: hw/rtl/alep_out_stage.sv
// ----------------------------------------------------------------------------
// alep_out_stage
// Result register: holds one result transaction until it is taken.
// ----------------------------------------------------------------------------
module alep_out_stage
  import alep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

// File: hw/rtl/at_link_event_parser_core.sv
// ----------------------------------------------------------------------------
// at_link_event_parser_core
// Parses the receive byte stream of a multi-link Wi-Fi module into events.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle unless a held result stalls
//   stage 1; the parser state update is a single combinational pass
//   between the input and result registers.
// Reset: synchronous active-low rst_n empties both registers, puts the parser
//   at line start and clears the active link. No clearing sweep is needed.
// ----------------------------------------------------------------------------
module at_link_event_parser_core
  import alep_pkg::*;
#(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF   // payload length counter width
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Stage 1: registered input transaction
  logic      s1_valid;
  in_item_t  s1_data;

  // Parser output for the transaction in stage 1
  logic      res_valid;
  out_item_t res;

  // Result slot is free when empty or being drained this cycle
  logic      out_free;
  logic      adv;

  // A transaction leaves stage 1 when it has no result, or when the result
  // register can take its result. Items that produce nothing never stall.
  assign adv = s1_valid && (!res_valid || out_free);

  alep_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // Parser state only advances with the transaction it consumes
  alep_parser #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .item      (s1_data),
    .res_valid (res_valid),
    .res       (res)
  );

  alep_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/alep_checker.sv
// ----------------------------------------------------------------------------
// alep_checker
// Port-level checks for the link event parser, bound to the top level.
// ----------------------------------------------------------------------------
module alep_checker
  import alep_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A fresh result into an empty result register comes from an input transaction
  // that was registered in stage 1 and then loaded into the result register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(out_valid) && out_valid |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding input transaction");

  // Only a closed event can report the active link cleared
  a_was_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_active |-> out_data.event_res == EV_CLOSED)
    else $error("was_active on a non-closed event");

  // Packet start never carries a zero length; other events carry none
  a_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_res == EV_PKT_START) == (out_data.length != 16'd0))
    else $error("length field inconsistent with event");

endmodule

bind at_link_event_parser_core alep_checker u_alep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
